@@ rtl/core/dem_pkg.sv @@
// ----------------------------------------------------------------------------
// dem_pkg: shared types and constants of the disparity edge mask
// Holds the transaction structs, stage control structs and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dem_pkg;

   // Frame size limits.
   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned MAX_HEIGHT = 1024;
   localparam int unsigned MIN_DIM    = 3;

   // Field and register widths.
   localparam int unsigned PIX_W       = 8;
   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned CSR_INDEX_W = 2;

   // Column counter indexes the line memories; row counter runs two rows past
   // the frame while the tail drains.
   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 3);

   // Columns held by the cell chain (3x3 window).
   localparam int unsigned WINDOW = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT    = 2'd2;

   // Reset values of the registers.
   localparam logic [PIX_W-1:0]      THRESHOLD_RESET = 8'd3;
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET     = 11'd450;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET    = 11'd375;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [PIX_W-1:0] disparity_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] disparity_out;
      logic             edge_mark;
      logic             transparent;
      logic             last_pixel;
   } rsp_type;

   // One column of the window: r0 is the newest row, r2 the oldest.
   typedef struct packed {
      logic [PIX_W-1:0] r0;
      logic [PIX_W-1:0] r1;
      logic [PIX_W-1:0] r2;
   } pix_col_type;

   typedef struct packed {
      logic r0;
      logic r1;
      logic r2;
   } flag_col_type;

   // Contents of one line memory entry: the two older rows of a column.
   typedef struct packed {
      logic [PIX_W-1:0] r1;
      logic [PIX_W-1:0] r2;
   } pix_pair_type;

   typedef struct packed {
      logic r1;
      logic r2;
   } flag_pair_type;

   // Item handed from the input sequencer to the datapath.
   typedef struct packed {
      logic             go;
      logic             test;
      logic             emit;
      logic             last;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] disparity;
   } item_type;

   // Control that travels with an item down the pipeline.
   typedef struct packed {
      logic             test;
      logic             emit;
      logic             last;
      logic [COL_W-1:0] col;
   } stage_ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/disparity_edge_mask.sv @@
// ----------------------------------------------------------------------------
// disparity_edge_mask: depth-discontinuity mask with 3x3 dilation
// Streams raster-order disparity pixels and reports each pixel with its
// edge mark and transparency flag.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock and keeps that rate as long as
// results are taken. Each pixel is reported 2*width+2 transactions after it
// arrived; once the frame is complete, 2*width+2 flush transactions drain the
// rest, and the last one carries last_pixel. A result passes through the
// stage registers s1 to s4 and then the result queue. The rate is set by the
// two line memories, each of which does one read and one write per cycle,
// feeding a chain of three column cells for the disparity window and the
// same cells again for the edge flag window. Writing the width or height
// restarts the frame. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_edge_mask (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  dem_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output dem_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write_en,
   input  logic [dem_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dem_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   dem_pkg::item_type          item;
   logic [dem_pkg::PIX_W-1:0]  threshold;
   logic                       adv;
   logic                       accept;
   logic                       enter;
   logic                       fifo_full;

   // Stage valid bits and stage control.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   dem_pkg::stage_ctl_type     s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic [dem_pkg::PIX_W-1:0]  s1_disp_ff, s3_disp_ff, s4_disp_ff;
   logic                       s3_edge_ff;
   logic                       s1_move, s2_move, s3_move;

   dem_pkg::pix_pair_type      pix_rd, pix_wr;
   dem_pkg::flag_pair_type     flag_rd, flag_wr;
   dem_pkg::pix_col_type       pix_feed [dem_pkg::WINDOW];
   dem_pkg::pix_col_type       pix_col  [dem_pkg::WINDOW];
   dem_pkg::flag_col_type      flag_feed [dem_pkg::WINDOW];
   dem_pkg::flag_col_type      flag_col  [dem_pkg::WINDOW];

   logic                       edge_hit;
   logic                       mark;
   logic                       push;
   dem_pkg::rsp_type           push_data;

   function automatic logic exceeds(
      input logic [dem_pkg::PIX_W-1:0] centre,
      input logic [dem_pkg::PIX_W-1:0] nb,
      input logic [dem_pkg::PIX_W-1:0] thr
   );
      logic [dem_pkg::PIX_W:0] diff;
      diff = {1'b0, centre} - {1'b0, nb};
      return !diff[dem_pkg::PIX_W] && (diff[dem_pkg::PIX_W-1:0] > thr);
   endfunction

   dem_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .accept       (accept),
      .item         (item),
      .threshold    (threshold)
   );

   // The whole pipeline moves together whenever the result queue has room.
   assign adv       = !fifo_full;
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign enter     = accept && item.go;
   assign s1_move   = adv && s1_valid_ff;
   assign s2_move   = adv && s2_valid_ff;
   assign s3_move   = adv && s3_valid_ff;

   always_comb begin
      s1_valid_in = adv ? enter       : s1_valid_ff;
      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = adv ? s2_valid_ff : s3_valid_ff;
      s4_valid_in = adv ? s3_valid_ff : s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctl_ff  <= '{test: item.test, emit: item.emit, last: item.last, col: item.col};
         s1_disp_ff <= item.disparity;
         s2_ctl_ff  <= s1_ctl_ff;
         s3_ctl_ff  <= s2_ctl_ff;
         s3_edge_ff <= s2_valid_ff && s2_ctl_ff.test && edge_hit;
         s3_disp_ff <= pix_col[dem_pkg::WINDOW-1].r2;
         s4_ctl_ff  <= s3_ctl_ff;
         s4_disp_ff <= s3_disp_ff;
      end
   end

   // Pixel line memory: each column entry keeps the two rows above.
   always_comb begin
      pix_wr.r1 = s1_disp_ff;
      pix_wr.r2 = pix_rd.r1;
   end

   dem_ram #(
      .DATA_W ($bits(dem_pkg::pix_pair_type)),
      .DEPTH  (dem_pkg::MAX_WIDTH)
   ) u_pix_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_ctl_ff.col),
      .wr_data (pix_wr),
      .rd_en   (enter),
      .rd_addr (item.col),
      .rd_data (pix_rd)
   );

   // Edge flag line memory, same arrangement later: written from s3, read at s2.
   always_comb begin
      flag_wr.r1 = s3_edge_ff;
      flag_wr.r2 = flag_rd.r1;
   end

   dem_ram #(
      .DATA_W ($bits(dem_pkg::flag_pair_type)),
      .DEPTH  (dem_pkg::MAX_WIDTH)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (s3_move),
      .wr_addr (s3_ctl_ff.col),
      .wr_data (flag_wr),
      .rd_en   (s2_move),
      .rd_addr (s2_ctl_ff.col),
      .rd_data (flag_rd)
   );

   always_comb begin
      pix_feed[0]  = '{r0: s1_disp_ff, r1: pix_rd.r1, r2: pix_rd.r2};
      flag_feed[0] = '{r0: s3_edge_ff, r1: flag_rd.r1, r2: flag_rd.r2};
   end

   for (genvar k = 0; k < dem_pkg::WINDOW; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign pix_feed[k]  = pix_col[k-1];
         assign flag_feed[k] = flag_col[k-1];
      end
      dem_cell u_cell (
         .clock      (clock),
         .pix_shift  (s1_move),
         .pix_in     (pix_feed[k]),
         .pix_out    (pix_col[k]),
         .flag_shift (s3_move),
         .flag_in    (flag_feed[k]),
         .flag_out   (flag_col[k])
      );
   end

   // Window centre is the middle row of the middle cell; cell 0 is newest.
   always_comb begin
      edge_hit = exceeds(pix_col[1].r1, pix_col[0].r0, threshold) ||
                 exceeds(pix_col[1].r1, pix_col[0].r1, threshold) ||
                 exceeds(pix_col[1].r1, pix_col[0].r2, threshold) ||
                 exceeds(pix_col[1].r1, pix_col[1].r0, threshold) ||
                 exceeds(pix_col[1].r1, pix_col[1].r2, threshold) ||
                 exceeds(pix_col[1].r1, pix_col[2].r0, threshold) ||
                 exceeds(pix_col[1].r1, pix_col[2].r1, threshold) ||
                 exceeds(pix_col[1].r1, pix_col[2].r2, threshold);
   end

   // A pixel is marked when any centre in its 3x3 neighborhood is an edge.
   always_comb begin
      mark = 1'b0;
      for (int k = 0; k < dem_pkg::WINDOW; k++) begin
         mark = mark | flag_col[k].r0 | flag_col[k].r1 | flag_col[k].r2;
      end
   end

   always_comb begin
      push                    = adv && s4_valid_ff && s4_ctl_ff.emit;
      push_data.disparity_out = s4_disp_ff;
      push_data.edge_mark     = mark;
      push_data.transparent   = mark || (s4_disp_ff == '0);
      push_data.last_pixel    = s4_ctl_ff.last;
   end

   dem_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/core/dem_ram.sv @@
// ----------------------------------------------------------------------------
// dem_ram: simple dual-port line memory
// One write port and one enabled read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dem_ram #(
   parameter int unsigned DATA_W = 16,
   parameter int unsigned DEPTH  = 1024
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/dem_cell.sv @@
// ----------------------------------------------------------------------------
// dem_cell: one column cell of the 3x3 window chain
// Holds one pixel column and one edge flag column and passes each on to the
// next cell when its side of the pipeline advances.
// ----------------------------------------------------------------------------
`default_nettype none

module dem_cell (
   input  logic                  clock,
   input  logic                  pix_shift,
   input  dem_pkg::pix_col_type  pix_in,
   output dem_pkg::pix_col_type  pix_out,
   input  logic                  flag_shift,
   input  dem_pkg::flag_col_type flag_in,
   output dem_pkg::flag_col_type flag_out
);

   dem_pkg::pix_col_type  pix_ff;
   dem_pkg::pix_col_type  pix_in_w;
   dem_pkg::flag_col_type flag_ff;
   dem_pkg::flag_col_type flag_in_w;

   always_comb begin
      pix_in_w  = pix_shift  ? pix_in  : pix_ff;
      flag_in_w = flag_shift ? flag_in : flag_ff;
   end

   always_ff @(posedge clock) begin
      pix_ff  <= pix_in_w;
      flag_ff <= flag_in_w;
   end

   assign pix_out  = pix_ff;
   assign flag_out = flag_ff;

endmodule

`default_nettype wire

@@ rtl/core/dem_ctrl.sv @@
// ----------------------------------------------------------------------------
// dem_ctrl: configuration registers and input sequencer
// Tracks the raster position of the next transaction, including the flush
// positions past the frame, and decides what each transaction does.
// ----------------------------------------------------------------------------
`default_nettype none

module dem_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [dem_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dem_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  dem_pkg::req_type                    req_data,
   input  logic                                accept,
   output dem_pkg::item_type                   item,
   output logic [dem_pkg::PIX_W-1:0]           threshold
);

   logic [dem_pkg::PIX_W-1:0]      threshold_ff, threshold_in;
   logic [dem_pkg::CSR_DATA_W-1:0] width_ff, width_in;
   logic [dem_pkg::CSR_DATA_W-1:0] height_ff, height_in;
   logic [dem_pkg::ROW_W-1:0]      row_ff, row_in;
   logic [dem_pkg::COL_W-1:0]      col_ff, col_in;

   logic in_frame;
   logic real_pix;
   logic flush_ok;
   logic col_wrap;

   function automatic logic [dem_pkg::CSR_DATA_W-1:0] clamp_dim(
      input logic [dem_pkg::CSR_DATA_W-1:0] raw,
      input int unsigned                    limit
   );
      logic [dem_pkg::CSR_DATA_W-1:0] res;
      if (32'(raw) < dem_pkg::MIN_DIM) begin
         res = dem_pkg::CSR_DATA_W'(dem_pkg::MIN_DIM);
      end else if (32'(raw) > limit) begin
         res = dem_pkg::CSR_DATA_W'(limit);
      end else begin
         res = raw;
      end
      return res;
   endfunction

   always_comb begin
      in_frame = 32'(row_ff) < 32'(height_ff);
      real_pix = (req_data.op == dem_pkg::OP_PIXEL) && in_frame;
      flush_ok = (req_data.op == dem_pkg::OP_FLUSH) && !in_frame;
      col_wrap = (32'(col_ff) + 32'd1) >= 32'(width_ff);

      item.go        = real_pix || flush_ok;
      item.test      = real_pix && (32'(row_ff) >= 32'd2) && (32'(col_ff) >= 32'd2);
      // The reported pixel trails the arriving one by two rows and two columns.
      item.emit      = (32'(row_ff) > 32'd2) || ((32'(row_ff) == 32'd2) &&
                                                 (32'(col_ff) >= 32'd2));
      // The last pixel of the frame leaves with the flush two rows and one
      // column past the end of the frame.
      item.last      = flush_ok && (32'(row_ff) == (32'(height_ff) + 32'd2)) &&
                       (32'(col_ff) == 32'd1);
      item.col       = col_ff;
      item.disparity = req_data.disparity_in;
   end

   always_comb begin
      threshold_in = threshold_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            dem_pkg::CSR_THRESHOLD: begin
               threshold_in = csr_wdata[dem_pkg::PIX_W-1:0];
            end
            dem_pkg::CSR_WIDTH: begin
               width_in = clamp_dim(csr_wdata, dem_pkg::MAX_WIDTH);
               row_in   = '0;
               col_in   = '0;
            end
            dem_pkg::CSR_HEIGHT: begin
               height_in = clamp_dim(csr_wdata, dem_pkg::MAX_HEIGHT);
               row_in    = '0;
               col_in    = '0;
            end
            default: begin
            end
         endcase
      end else if (accept && item.go) begin
         priority if (item.last) begin
            row_in = '0;
            col_in = '0;
         end else if (col_wrap) begin
            row_in = row_ff + dem_pkg::ROW_W'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + dem_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= dem_pkg::THRESHOLD_RESET;
         width_ff     <= dem_pkg::WIDTH_RESET;
         height_ff    <= dem_pkg::HEIGHT_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         threshold_ff <= threshold_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   assign threshold = threshold_ff;

endmodule

`default_nettype wire

@@ rtl/core/dem_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// dem_rsp_fifo: two-entry result queue
// Decouples the pipeline from the result channel so that a new transaction
// is taken while a finished result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module dem_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dem_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dem_pkg::rsp_type rsp_data
);

   localparam int unsigned DEPTH = 2;

   dem_pkg::rsp_type             entry_ff [DEPTH];
   logic [$clog2(DEPTH)-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [$clog2(DEPTH)-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [$clog2(DEPTH+1)-1:0]   count_ff, count_in;
   logic                         pop;

   always_comb begin
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (32'(count_ff) == DEPTH);
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

@@ rtl/core/dem_checker.sv @@
// ----------------------------------------------------------------------------
// dem_checker: port-level checks of the disparity edge mask
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module dem_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input dem_pkg::rsp_type rsp_data
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Transparency always follows the mark and the disparity value.
   a_transparent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.transparent ==
                    (rsp_data.edge_mark || (rsp_data.disparity_out == '0)))
      else $error("transparent flag inconsistent with mark and disparity");

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result present right after reset");

   // With no result waiting, the input side is never stalled.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result queue");

   // A transaction offered with no result waiting is taken at once.
   a_take_offer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_valid && req_ready)
      else $error("offered transaction not taken while result queue is empty");

endmodule

bind disparity_edge_mask dem_checker u_dem_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
